// ----- hw/rtl/gnms_pkg.sv -----
// gnms_pkg: shared constants, types and controller/datapath bundles for the
// bilinear non-maximum suppression block. No dependencies.
package gnms_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int WIDTH_W     = COL_W + 1;
  localparam int ROW_W       = 16;
  localparam int SAMPLE_BITS = 16;
  localparam int WFB         = 14;
  localparam int DIR_W       = WFB + 2;
  localparam int WGT_W       = WFB + 1;
  localparam int WT_W        = 2 * WFB + 1;
  localparam int ACC_W       = SAMPLE_BITS + WT_W;
  localparam int CNT_W       = $clog2(WFB);
  localparam int TAPS        = 4;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH    = 2'd0,
    CFG_FRAME_HEIGHT   = 2'd1,
    CFG_WEAK_THRESHOLD = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_EVAL,
    ST_DIV,
    ST_PROBE,
    ST_CHECK,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic       in_ready;
    logic       load;
    logic       res_keep;
    logic       div_init;
    logic       div_step;
    logic       acc_clr;
    logic       tap_en;
    logic       mac_en;
    logic       probe_bwd;
    logic [1:0] tap;
    logic       out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_fire;
    logic in_flush;
    logic owed_zero;
    logic emit;
    logic interior;
    logic low_mag;
    logic probe_fail;
    logic out_full;
  } ctrl_sts_t;

endpackage

// ----- hw/rtl/gnms_ifs.sv -----
// gnms stream and configuration channel interfaces
// depends on gnms_pkg for field widths
interface gnms_in_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  mode;
  logic signed [gnms_pkg::SAMPLE_BITS-1:0] grad_x;
  logic signed [gnms_pkg::SAMPLE_BITS-1:0] grad_y;
  logic        [gnms_pkg::SAMPLE_BITS-1:0] magnitude;
  modport source (output valid, mode, grad_x, grad_y, magnitude, input ready);
  modport sink   (input valid, mode, grad_x, grad_y, magnitude, output ready);
endinterface

interface gnms_out_if;
  logic                             valid;
  logic                             ready;
  logic [gnms_pkg::SAMPLE_BITS-1:0] edge_value;
  logic                             frame_last;
  modport source (output valid, edge_value, frame_last, input ready);
  modport sink   (input valid, edge_value, frame_last, output ready);
endinterface

interface gnms_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [gnms_pkg::CFG_IDX_W-1:0]  index;
  logic [gnms_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/gnms_ctrl.sv -----
// gnms_ctrl: sequencer for one item at a time (load, direction divide, probes)
// depends on gnms_pkg
module gnms_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  gnms_pkg::ctrl_sts_t sts_i,
  output gnms_pkg::ctrl_cmd_t cmd_o
);

  gnms_pkg::state_e state_q, state_d;
  logic [gnms_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic bwd_q, bwd_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gnms_pkg::ST_IDLE;
      cnt_q   <= '0;
      bwd_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      bwd_q   <= bwd_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    bwd_d   = bwd_q;
    case (state_q)
      gnms_pkg::ST_IDLE: begin
        if (sts_i.in_fire) begin
          if (!sts_i.in_flush) state_d = gnms_pkg::ST_LOAD;
          else if (!sts_i.owed_zero) state_d = gnms_pkg::ST_DONE;
        end
      end
      gnms_pkg::ST_LOAD: state_d = gnms_pkg::ST_EVAL;
      gnms_pkg::ST_EVAL: begin
        if (!sts_i.emit) state_d = gnms_pkg::ST_IDLE;
        else if (!sts_i.interior || sts_i.low_mag) state_d = gnms_pkg::ST_DONE;
        else begin
          state_d = gnms_pkg::ST_DIV;
          cnt_d   = '0;
        end
      end
      gnms_pkg::ST_DIV: begin
        if (cnt_q == gnms_pkg::CNT_W'(gnms_pkg::WFB - 1)) begin
          state_d = gnms_pkg::ST_PROBE;
          cnt_d   = '0;
          bwd_d   = 1'b0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      gnms_pkg::ST_PROBE: begin
        if (cnt_q == gnms_pkg::CNT_W'(gnms_pkg::TAPS)) state_d = gnms_pkg::ST_CHECK;
        else cnt_d = cnt_q + 1'b1;
      end
      gnms_pkg::ST_CHECK: begin
        if (sts_i.probe_fail || bwd_q) state_d = gnms_pkg::ST_DONE;
        else begin
          state_d = gnms_pkg::ST_PROBE;
          cnt_d   = '0;
          bwd_d   = 1'b1;
        end
      end
      gnms_pkg::ST_DONE: begin
        if (!sts_i.out_full) state_d = gnms_pkg::ST_IDLE;
      end
      default: state_d = gnms_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o           = '0;
    cmd_o.probe_bwd = bwd_q;
    cmd_o.tap       = cnt_q[1:0];
    case (state_q)
      gnms_pkg::ST_IDLE: cmd_o.in_ready = 1'b1;
      gnms_pkg::ST_LOAD: cmd_o.load = 1'b1;
      gnms_pkg::ST_EVAL: begin
        cmd_o.div_init = sts_i.emit && sts_i.interior && !sts_i.low_mag;
      end
      gnms_pkg::ST_DIV: cmd_o.div_step = 1'b1;
      gnms_pkg::ST_PROBE: begin
        cmd_o.acc_clr = (cnt_q == '0);
        cmd_o.tap_en  = (cnt_q < gnms_pkg::CNT_W'(gnms_pkg::TAPS));
        cmd_o.mac_en  = (cnt_q != '0);
      end
      gnms_pkg::ST_CHECK: begin
        cmd_o.res_keep = !sts_i.probe_fail && bwd_q;
      end
      gnms_pkg::ST_DONE: cmd_o.out_load = !sts_i.out_full;
      default: cmd_o.in_ready = 1'b0;
    endcase
  end

endmodule

// ----- hw/rtl/gnms_dp.sv -----
// gnms_dp: config registers, line buffers, 3x3 window, direction divider,
// tap weights and accumulator, output register. depends on gnms_pkg, gnms_ifs
module gnms_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  gnms_in_if.sink             pix_i,
  gnms_out_if.source          edge_o,
  gnms_cfg_if.sink            cfg_i,
  input  gnms_pkg::ctrl_cmd_t cmd_i,
  output gnms_pkg::ctrl_sts_t sts_o
);

  localparam int SB = gnms_pkg::SAMPLE_BITS;
  localparam int WF = gnms_pkg::WFB;

  // configuration
  logic [gnms_pkg::WIDTH_W-1:0] fw_q;
  logic [gnms_pkg::ROW_W-1:0]   fh_q;
  logic [SB-1:0]                thr_q;
  logic [gnms_pkg::WIDTH_W-1:0] w_eff;
  logic [gnms_pkg::ROW_W-1:0]   h_eff;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q  <= gnms_pkg::WIDTH_W'(640);
      fh_q  <= gnms_pkg::ROW_W'(480);
      thr_q <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        gnms_pkg::CFG_FRAME_WIDTH:    fw_q  <= cfg_i.data[gnms_pkg::WIDTH_W-1:0];
        gnms_pkg::CFG_FRAME_HEIGHT:   fh_q  <= cfg_i.data[gnms_pkg::ROW_W-1:0];
        gnms_pkg::CFG_WEAK_THRESHOLD: thr_q <= cfg_i.data[SB-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (fw_q < gnms_pkg::WIDTH_W'(3)) w_eff = gnms_pkg::WIDTH_W'(3);
    else if (fw_q > gnms_pkg::WIDTH_W'(gnms_pkg::MAX_WIDTH))
      w_eff = gnms_pkg::WIDTH_W'(gnms_pkg::MAX_WIDTH);
    else w_eff = fw_q;
    h_eff = (fh_q < gnms_pkg::ROW_W'(3)) ? gnms_pkg::ROW_W'(3) : fh_q;
  end

  // position counters
  logic [gnms_pkg::COL_W-1:0]   col_q, col_d, col_w, c_q;
  logic [gnms_pkg::ROW_W-1:0]   row_q, row_d, row_w, r_q;
  logic [gnms_pkg::WIDTH_W-1:0] owed_q, owed_d;
  logic [gnms_pkg::ROW_W:0]     row_t, row_n;
  logic [gnms_pkg::WIDTH_W-1:0] col_n;
  logic                         fire, flush, pix_fire, emit_now, emit_q;
  logic                         col_wrap;

  assign fire     = pix_i.valid && cmd_i.in_ready;
  assign flush    = pix_i.mode;
  assign pix_fire = fire && !flush;
  assign pix_i.ready = cmd_i.in_ready;

  always_comb begin
    col_wrap = {1'b0, col_q} >= w_eff;
    col_w    = col_wrap ? '0 : col_q;
    row_t    = {1'b0, row_q} + (col_wrap ? 1'b1 : 1'b0);
    row_w    = (row_t >= {1'b0, h_eff}) ? '0 : row_t[gnms_pkg::ROW_W-1:0];
    emit_now = {1'b0, owed_q} >= ({1'b0, w_eff} + 1'b1);
    col_n    = {1'b0, col_w} + 1'b1;
    row_n    = '0;
    col_d    = col_w;
    row_d    = row_w;
    owed_d   = owed_q;
    if (flush) begin
      col_d  = col_q;
      row_d  = row_q;
      owed_d = (owed_q == '0) ? owed_q : owed_q - 1'b1;
    end else begin
      owed_d = emit_now ? w_eff + 1'b1 : owed_q + 1'b1;
      if (col_n >= w_eff) begin
        col_d = '0;
        row_n = {1'b0, row_w} + 1'b1;
        row_d = (row_n >= {1'b0, h_eff}) ? '0 : row_n[gnms_pkg::ROW_W-1:0];
      end else begin
        col_d = col_n[gnms_pkg::COL_W-1:0];
        row_n = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      owed_q <= '0;
      emit_q <= 1'b0;
    end else if (fire) begin
      col_q  <= col_d;
      row_q  <= row_d;
      owed_q <= owed_d;
      emit_q <= !flush && emit_now;
    end
  end

  // line buffers, read-first
  logic [SB-1:0]   bank_a [gnms_pkg::MAX_WIDTH];
  logic [SB-1:0]   bank_b [gnms_pkg::MAX_WIDTH];
  logic [2*SB-1:0] grad_mem [gnms_pkg::MAX_WIDTH];
  logic [SB-1:0]   rd_a_q, rd_b_q, mag_q;
  logic [2*SB-1:0] grad_rd_q, hold_q, cg_q;

  always_ff @(posedge clk_i) begin
    if (pix_fire) begin
      rd_b_q         <= bank_b[col_w];
      bank_b[col_w]  <= pix_i.magnitude;
      grad_rd_q      <= grad_mem[col_w];
      grad_mem[col_w] <= {pix_i.grad_y, pix_i.grad_x};
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_fire) rd_a_q <= bank_a[col_w];
    if (cmd_i.load) bank_a[c_q] <= rd_b_q;
  end

  always_ff @(posedge clk_i) begin
    if (pix_fire) begin
      c_q   <= col_w;
      r_q   <= row_w;
      mag_q <= pix_i.magnitude;
    end
    if (cmd_i.load) begin
      cg_q   <= hold_q;
      hold_q <= grad_rd_q;
    end
  end

  // 3x3 window
  logic [SB-1:0] win_q [9];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 9; i++) win_q[i] <= '0;
    end else if (cmd_i.load) begin
      for (int k = 0; k < 3; k++) begin
        win_q[k*3]   <= win_q[k*3+1];
        win_q[k*3+1] <= win_q[k*3+2];
      end
      win_q[2] <= rd_a_q;
      win_q[5] <= rd_b_q;
      win_q[8] <= mag_q;
    end
  end

  logic [SB-1:0] cm;
  assign cm = win_q[4];

  // direction divider, two lanes, one quotient bit per cycle
  logic signed [SB-1:0]    gx, gy;
  logic [SB-1:0]           abs_x, abs_y, rem_x_q, rem_y_q;
  logic [SB:0]             sh_x, sh_y;
  logic [WF-1:0]           q_x_q, q_y_q;
  logic                    sat_x_q, sat_y_q, neg_x_q, neg_y_q;
  logic signed [gnms_pkg::DIR_W-1:0] nx, ny;

  assign gx    = cg_q[SB-1:0];
  assign gy    = cg_q[2*SB-1:SB];
  assign abs_x = gx[SB-1] ? SB'(-gx) : gx;
  assign abs_y = gy[SB-1] ? SB'(-gy) : gy;
  assign sh_x  = {rem_x_q, 1'b0};
  assign sh_y  = {rem_y_q, 1'b0};

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      rem_x_q <= abs_x;
      rem_y_q <= abs_y;
      sat_x_q <= abs_x >= cm;
      sat_y_q <= abs_y >= cm;
      neg_x_q <= gx[SB-1];
      neg_y_q <= gy[SB-1];
      q_x_q   <= '0;
      q_y_q   <= '0;
    end else if (cmd_i.div_step) begin
      if (sh_x >= {1'b0, cm}) begin
        rem_x_q <= SB'(sh_x - {1'b0, cm});
        q_x_q   <= {q_x_q[WF-2:0], 1'b1};
      end else begin
        rem_x_q <= sh_x[SB-1:0];
        q_x_q   <= {q_x_q[WF-2:0], 1'b0};
      end
      if (sh_y >= {1'b0, cm}) begin
        rem_y_q <= SB'(sh_y - {1'b0, cm});
        q_y_q   <= {q_y_q[WF-2:0], 1'b1};
      end else begin
        rem_y_q <= sh_y[SB-1:0];
        q_y_q   <= {q_y_q[WF-2:0], 1'b0};
      end
    end
  end

  localparam logic signed [gnms_pkg::DIR_W-1:0] DONE_ONE = gnms_pkg::DIR_W'(1 << WF);

  always_comb begin
    logic signed [gnms_pkg::DIR_W-1:0] mx, my;
    mx = sat_x_q ? DONE_ONE : gnms_pkg::DIR_W'(q_x_q);
    my = sat_y_q ? DONE_ONE : gnms_pkg::DIR_W'(q_y_q);
    nx = neg_x_q ? -mx : mx;
    ny = neg_y_q ? -my : my;
  end

  // tap weights and accumulate
  logic signed [gnms_pkg::DIR_W-1:0] vx, vy;
  logic [WF-1:0]            dx, dy;
  logic [1:0]               lx, ly, ix, iy;
  logic [gnms_pkg::WGT_W-1:0] wx, wy;
  logic [2*gnms_pkg::WGT_W-1:0] wprod;
  logic [3:0]               widx;
  logic                     tap_ok;
  logic [gnms_pkg::WT_W-1:0] wt_q;
  logic [SB-1:0]            val_q;
  logic [gnms_pkg::ACC_W-1:0] acc_q, ref_v;

  always_comb begin
    vx = cmd_i.probe_bwd ? -nx : nx;
    vy = cmd_i.probe_bwd ? -ny : ny;
    dx = vx[WF-1:0];
    dy = vy[WF-1:0];
    // top bits give the floor offset of the sample cell, -1..1
    lx = vx[WF+1:WF] + 2'd1;
    ly = vy[WF+1:WF] + 2'd1;
    ix = lx + {1'b0, cmd_i.tap[0]};
    iy = ly + {1'b0, cmd_i.tap[1]};
    wx = cmd_i.tap[0] ? {1'b0, dx} : gnms_pkg::WGT_W'((1 << WF) - dx);
    wy = cmd_i.tap[1] ? {1'b0, dy} : gnms_pkg::WGT_W'((1 << WF) - dy);
    wprod  = wx * wy;
    tap_ok = (ix != 2'd3) && (iy != 2'd3);
    widx   = {2'b00, iy} * 4'd3 + {2'b00, ix};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.tap_en) begin
      wt_q  <= wprod[gnms_pkg::WT_W-1:0];
      val_q <= tap_ok ? win_q[widx] : '0;
    end
    if (cmd_i.acc_clr) acc_q <= '0;
    else if (cmd_i.mac_en)
      acc_q <= acc_q + gnms_pkg::ACC_W'(val_q) * gnms_pkg::ACC_W'(wt_q);
  end

  // a sample leaves the image only at the last column or row with a full step
  logic at_right, at_bot, out_f, out_b, fail;
  assign at_right = ({1'b0, c_q} == w_eff - 1'b1);
  assign at_bot   = (r_q == h_eff - 1'b1);
  assign out_f = (at_right && nx == DONE_ONE) || (at_bot && ny == DONE_ONE);
  assign out_b = (at_right && nx == -DONE_ONE) || (at_bot && ny == -DONE_ONE);
  assign ref_v = gnms_pkg::ACC_W'({cm, {(2*WF){1'b0}}});
  assign fail  = cmd_i.probe_bwd ? (out_b || ref_v < acc_q) : (out_f || ref_v <= acc_q);

  // result and output register
  logic [SB-1:0] res_q;
  logic          last_q;
  logic          ovalid_q;
  logic [SB-1:0] oval_q;
  logic          olast_q;

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q  <= '0;
      last_q <= flush ? (owed_q == gnms_pkg::WIDTH_W'(1) && col_q == '0 && row_q == '0)
                      : (emit_now && col_w == '0 && row_w == gnms_pkg::ROW_W'(1));
    end else if (cmd_i.res_keep) begin
      res_q <= cm;
    end
    if (cmd_i.out_load) begin
      oval_q  <= res_q;
      olast_q <= last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ovalid_q <= 1'b0;
    else if (cmd_i.out_load) ovalid_q <= 1'b1;
    else if (edge_o.ready) ovalid_q <= 1'b0;
  end

  assign edge_o.valid      = ovalid_q;
  assign edge_o.edge_value = oval_q;
  assign edge_o.frame_last = olast_q;

  always_comb begin
    sts_o            = '0;
    sts_o.in_fire    = fire;
    sts_o.in_flush   = flush;
    sts_o.owed_zero  = (owed_q == '0);
    sts_o.emit       = emit_q;
    sts_o.interior   = (c_q >= gnms_pkg::COL_W'(2)) && (r_q >= gnms_pkg::ROW_W'(2));
    sts_o.low_mag    = (cm <= thr_q);
    sts_o.probe_fail = fail;
    sts_o.out_full   = ovalid_q && !edge_o.ready;
  end

endmodule

// ----- hw/rtl/gradient_nms_2d_interp_top.sv -----
// channel   dir  modport  payload
// pix_i     in   sink     mode, grad_x, grad_y, magnitude
// edge_o    out  source   edge_value, frame_last
// cfg_i     in   sink     index, data (always ready)
//
// one item at a time: a pixel with no result passes load and evaluate, a
// border or weak pixel also done; an interior pixel adds a direction divide
// and two tap probes through one weight multiplier and one mac, each
// followed by a compare state, stopping after the forward probe if it
// rejects. flush items go to done only when a result is owed. results wait
// in an output register while the next item is taken. reset is async active
// low; the line buffers are not cleared, counters and the window are.
module gradient_nms_2d_interp_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  gnms_in_if.sink    pix_i,
  gnms_out_if.source edge_o,
  gnms_cfg_if.sink   cfg_i
);

  gnms_pkg::ctrl_cmd_t cmd;
  gnms_pkg::ctrl_sts_t sts;

  gnms_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  gnms_dp u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pix_i),
    .edge_o (edge_o),
    .cfg_i  (cfg_i),
    .cmd_i  (cmd),
    .sts_o  (sts)
  );

endmodule

// ----- verif/tb.sv -----
// tb: self-checking bench for gradient_nms_2d_interp_top, bilinear canny thinning
// depends on gnms_pkg, gnms_ifs and the rtl top level
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint ONE = 64'd1 << gnms_pkg::WFB;
  localparam int X_PRED = 0;
  localparam int X_NONE = 1;
  localparam int X_ZERO = 2;
  localparam int K_PIX = 0;
  localparam int K_FLUSH = 1;
  localparam int K_CFG = 2;

  typedef struct {
    logic [15:0] edge_value;
    logic        frame_last;
  } nms_res_t;

  typedef struct {
    int          kind;
    logic [15:0] a;
    logic [15:0] b;
    logic [15:0] c;
    int          xk;
    bit          xl;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  gnms_in_if  pix_if ();
  gnms_out_if res_if ();
  gnms_cfg_if cfg_if ();

  gradient_nms_2d_interp_top u_top (
    .clk_i (clk),
    .rst_ni(rst_n),
    .pix_i (pix_if),
    .edge_o(res_if),
    .cfg_i (cfg_if)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state
  logic [15:0] mag_ln [0:2*gnms_pkg::MAX_WIDTH-1];
  logic [31:0] grad_ln[0:gnms_pkg::MAX_WIDTH];
  logic [15:0] win[0:8];
  int unsigned col_pos, row_pos, owed;
  int unsigned cfg_w = 640, cfg_h = 480;
  logic [15:0] thresh = '0;
  nms_res_t pending_edges[$];
  int fails = 0;
  int sent = 0;
  bit quiet;

  function automatic int unsigned eff_w();
    return cfg_w < 3 ? 3 : (cfg_w > gnms_pkg::MAX_WIDTH ? gnms_pkg::MAX_WIDTH : cfg_w);
  endfunction

  function automatic int unsigned eff_h();
    return cfg_h < 3 ? 3 : cfg_h;
  endfunction

  // bilinear sample at (px, py) in units of 2^-14, window centered at (ox, oy)
  function automatic bit interp_at(longint px, longint py, longint ox, longint oy,
                                   output longint acc);
    longint xi, yi, lx, ly, wt, ix, iy;
    longint wx[2], wy[2];
    acc = 0;
    if (px < 0 || py < 0) return 0;
    if (px >= longint'(eff_w() - 1) * ONE) return 0;
    if (py >= longint'(eff_h() - 1) * ONE) return 0;
    xi = px >>> gnms_pkg::WFB;
    yi = py >>> gnms_pkg::WFB;
    wx[1] = px & (ONE - 1);
    wy[1] = py & (ONE - 1);
    wx[0] = ONE - wx[1];
    wy[0] = ONE - wy[1];
    lx = xi - ox + 1;
    ly = yi - oy + 1;
    for (int b = 0; b < 2; b++) begin
      for (int a = 0; a < 2; a++) begin
        wt = wx[a] * wy[b];
        ix = lx + a;
        iy = ly + b;
        if (wt != 0 && ix >= 0 && ix <= 2 && iy >= 0 && iy <= 2)
          acc += longint'(win[iy * 3 + ix]) * wt;
      end
    end
    return 1;
  endfunction

  function automatic logic [15:0] thin_value(logic [31:0] g, longint ox, longint oy);
    longint cm, nx, ny, ref_scaled, acc;
    cm = longint'(win[4]);
    if (win[4] <= thresh) return '0;
    nx = longint'($signed(g[15:0])) * ONE / cm;
    ny = longint'($signed(g[31:16])) * ONE / cm;
    if (nx > ONE) nx = ONE;
    if (nx < -ONE) nx = -ONE;
    if (ny > ONE) ny = ONE;
    if (ny < -ONE) ny = -ONE;
    ref_scaled = cm << (2 * gnms_pkg::WFB);
    if (!interp_at(ox * ONE + nx, oy * ONE + ny, ox, oy, acc)) return '0;
    if (ref_scaled <= acc) return '0;
    if (!interp_at(ox * ONE - nx, oy * ONE - ny, ox, oy, acc)) return '0;
    if (ref_scaled < acc) return '0;
    return win[4];
  endfunction

  function automatic bit predict_item(bit md, logic [15:0] gx, logic [15:0] gy,
                                      logic [15:0] mg, output nms_res_t r);
    int unsigned w, h, c, rr;
    logic [31:0] cg;
    bit emit;
    w = eff_w();
    h = eff_h();
    r.edge_value = '0;
    r.frame_last = 1'b0;
    if (md) begin
      if (owed == 0) return 0;
      r.frame_last = (owed == 1 && col_pos == 0 && row_pos == 0);
      owed--;
      return 1;
    end
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= h) row_pos = 0;
    c = col_pos;
    rr = row_pos;
    for (int k = 0; k < 3; k++) begin
      win[k*3] = win[k*3+1];
      win[k*3+1] = win[k*3+2];
    end
    win[2] = mag_ln[c];
    win[5] = mag_ln[gnms_pkg::MAX_WIDTH + c];
    win[8] = mg;
    mag_ln[c] = mag_ln[gnms_pkg::MAX_WIDTH + c];
    mag_ln[gnms_pkg::MAX_WIDTH + c] = mg;
    cg = grad_ln[gnms_pkg::MAX_WIDTH];
    grad_ln[gnms_pkg::MAX_WIDTH] = grad_ln[c];
    grad_ln[c] = {gy, gx};
    emit = owed >= w + 1;
    if (emit) begin
      owed = w + 1;
      if (c >= 2 && rr >= 2) r.edge_value = thin_value(cg, c - 1, rr - 1);
      r.frame_last = (c == 0 && rr == 1);
    end else begin
      owed++;
    end
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h) row_pos = 0;
    end
    return emit;
  endfunction

  task automatic send_item(bit md, logic [15:0] gx, logic [15:0] gy, logic [15:0] mg,
                           int xk, bit xl);
    bit took;
    nms_res_t r;
    if (!quiet && $urandom_range(0, 99) < 20) begin
      pix_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    pix_if.valid <= 1'b1;
    pix_if.mode <= md;
    pix_if.grad_x <= gx;
    pix_if.grad_y <= gy;
    pix_if.magnitude <= mg;
    do begin
      @(negedge clk);
      took = pix_if.ready;
      @(posedge clk);
    end while (!took);
    sent++;
    if (predict_item(md, gx, gy, mg, r) && xk == X_PRED) pending_edges.push_back(r);
    if (xk == X_ZERO) begin
      r.edge_value = '0;
      r.frame_last = xl;
      pending_edges.push_back(r);
    end
  endtask

  task automatic drain_owed();
    while (owed != 0) send_item(1'b1, '0, '0, '0, X_PRED, 1'b0);
  endtask

  task automatic write_reg(gnms_pkg::cfg_idx_e idx, logic [15:0] val);
    bit took;
    pix_if.valid <= 1'b0;
    while (pending_edges.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= val;
    do begin
      @(negedge clk);
      took = cfg_if.ready;
      @(posedge clk);
    end while (!took);
    cfg_if.valid <= 1'b0;
    case (idx)
      gnms_pkg::CFG_FRAME_WIDTH:  cfg_w = val[10:0];
      gnms_pkg::CFG_FRAME_HEIGHT: cfg_h = val;
      default:                    thresh = val;
    endcase
  endtask

  task automatic random_pixel();
    logic [15:0] mg, gx, gy;
    mg = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4095));
    if ($urandom_range(0, 1) == 0) begin
      gx = 16'($urandom);
      gy = 16'($urandom);
    end else begin
      gx = 16'(int'($urandom_range(0, 2 * mg)) - int'(mg));
      gy = 16'(int'($urandom_range(0, 2 * mg)) - int'(mg));
    end
    send_item(1'b0, gx, gy, mg, X_PRED, 1'b0);
  endtask

  always @(posedge clk) begin
    res_if.ready <= (quiet || $urandom_range(0, 99) >= 20);
  end

  always @(negedge clk) begin
    nms_res_t want;
    if (rst_n && res_if.valid && res_if.ready) begin
      if (pending_edges.size() == 0) begin
        $display("%0t: unexpected result edge_value=%h frame_last=%b", $realtime,
                 res_if.edge_value, res_if.frame_last);
        fails++;
      end else begin
        want = pending_edges.pop_front();
        if (res_if.edge_value !== want.edge_value) begin
          $display("%0t: edge_value expected %h actual %h", $realtime, want.edge_value,
                   res_if.edge_value);
          fails++;
        end
        if (res_if.frame_last !== want.frame_last) begin
          $display("%0t: frame_last expected %b actual %b", $realtime, want.frame_last,
                   res_if.frame_last);
          fails++;
        end
      end
    end
  end

  dir_row_t dir_rows[$];

  initial begin
    int rand_items;
    int frames;
    int unsigned npix;
    dir_row_t row;
    pix_if.valid = 1'b0;
    pix_if.mode = 1'b0;
    pix_if.grad_x = '0;
    pix_if.grad_y = '0;
    pix_if.magnitude = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = gnms_pkg::CFG_FRAME_WIDTH;
    cfg_if.data = '0;
    res_if.ready = 1'b0;
    quiet = 1'b0;
    for (int i = 0; i < 2 * gnms_pkg::MAX_WIDTH; i++) mag_ln[i] = '0;
    for (int i = 0; i <= gnms_pkg::MAX_WIDTH; i++) grad_ln[i] = '0;
    for (int i = 0; i < 9; i++) win[i] = '0;
    col_pos = 0;
    row_pos = 0;
    owed = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: 3x3 frames, all-weak first then strong center
    dir_rows = '{
      '{K_CFG, gnms_pkg::CFG_FRAME_WIDTH, 0, 0, X_NONE, 0},
      '{K_CFG, gnms_pkg::CFG_FRAME_HEIGHT, 0, 0, X_NONE, 0},
      '{K_CFG, gnms_pkg::CFG_WEAK_THRESHOLD, 16'hffff, 0, X_NONE, 0},
      '{K_PIX, 16'h8000, 16'h7fff, 16'hffff, X_NONE, 0},
      '{K_PIX, 16'h7fff, 16'h8000, 16'h0000, X_NONE, 0},
      '{K_PIX, 16'h0000, 16'h0000, 16'h0001, X_NONE, 0},
      '{K_PIX, 16'hffff, 16'hffff, 16'hfffe, X_NONE, 0},
      '{K_PIX, 16'h0100, 16'h0000, 16'hffff, X_ZERO, 0},
      '{K_PIX, 16'h5555, 16'haaaa, 16'h5555, X_ZERO, 0},
      '{K_PIX, 16'haaaa, 16'h5555, 16'haaaa, X_ZERO, 0},
      '{K_PIX, 16'h0000, 16'h0100, 16'h0100, X_ZERO, 0},
      '{K_PIX, 16'h8000, 16'h8000, 16'h8000, X_ZERO, 0},
      '{K_FLUSH, 0, 0, 0, X_ZERO, 0},
      '{K_FLUSH, 0, 0, 0, X_ZERO, 0},
      '{K_FLUSH, 0, 0, 0, X_ZERO, 0},
      '{K_FLUSH, 0, 0, 0, X_ZERO, 1},
      '{K_FLUSH, 0, 0, 0, X_NONE, 0},
      '{K_CFG, gnms_pkg::CFG_WEAK_THRESHOLD, 0, 0, X_NONE, 0},
      '{K_PIX, 16'h0000, 16'h0000, 16'h0010, X_PRED, 0},
      '{K_PIX, 16'h0000, 16'h0000, 16'h0020, X_PRED, 0},
      '{K_PIX, 16'h0000, 16'h0000, 16'h0010, X_PRED, 0},
      '{K_PIX, 16'h0100, 16'h0000, 16'h0020, X_PRED, 0},
      '{K_FLUSH, 0, 0, 0, X_PRED, 0},
      '{K_PIX, 16'h7fff, 16'h0000, 16'hffff, X_PRED, 0},
      '{K_PIX, 16'h0000, 16'h0100, 16'h0020, X_PRED, 0},
      '{K_PIX, 16'h0000, 16'h0000, 16'h0010, X_PRED, 0},
      '{K_PIX, 16'h00b5, 16'hff4b, 16'h0020, X_PRED, 0},
      '{K_PIX, 16'h0000, 16'h0000, 16'h0010, X_PRED, 0}
    };
    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.kind == K_CFG) write_reg(gnms_pkg::cfg_idx_e'(row.a[1:0]), row.b);
      else send_item(row.kind == K_FLUSH, row.a, row.b, row.c, row.xk, row.xl);
    end
    drain_owed();

    // random frames, whole frames per setting
    rand_items = 0;
    while (rand_items < 1350) begin
      drain_owed();
      write_reg(gnms_pkg::CFG_FRAME_WIDTH,
                ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 2))
                                            : 16'($urandom_range(3, 12)));
      write_reg(gnms_pkg::CFG_FRAME_HEIGHT,
                ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 2))
                                            : 16'($urandom_range(3, 6)));
      case ($urandom_range(0, 9))
        0, 1, 2: write_reg(gnms_pkg::CFG_WEAK_THRESHOLD, 16'd0);
        3:       write_reg(gnms_pkg::CFG_WEAK_THRESHOLD, 16'hffff);
        4:       write_reg(gnms_pkg::CFG_WEAK_THRESHOLD, 16'($urandom));
        default: write_reg(gnms_pkg::CFG_WEAK_THRESHOLD, 16'($urandom_range(0, 2048)));
      endcase
      frames = $urandom_range(1, 3);
      npix = eff_w() * eff_h() * frames;
      for (int unsigned i = 0; i < npix; i++) begin
        quiet = (rand_items >= 700 && rand_items < 1000);
        if ($urandom_range(0, 99) < 4 && owed != 0) begin
          send_item(1'b1, 16'($urandom), 16'($urandom), 16'($urandom), X_PRED, 1'b0);
          rand_items++;
        end
        random_pixel();
        rand_items++;
      end
    end
    quiet = 1'b0;

    // tallest frame, only partly streamed
    drain_owed();
    write_reg(gnms_pkg::CFG_FRAME_WIDTH, 16'd3);
    write_reg(gnms_pkg::CFG_FRAME_HEIGHT, 16'hffff);
    for (int i = 0; i < 36; i++) random_pixel();
    drain_owed();

    pix_if.valid <= 1'b0;
    while (pending_edges.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (fails == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #40_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/gnms_pkg.sv
hw/rtl/gnms_ifs.sv
hw/rtl/gnms_ctrl.sv
hw/rtl/gnms_dp.sv
hw/rtl/gradient_nms_2d_interp_top.sv
verif/tb.sv
